// ----- rtl/psc_pkg.sv -----
// Shared constants for the prime sieve counter.
// No dependencies; imported by prime_sieve_counter.
package psc_pkg;

   localparam int MAX_LIMIT_DEF = 65535;
   localparam int LIMIT_W       = 16;
   localparam int COUNT_W       = 13;

endpackage

// ----- rtl/prime_sieve_counter.sv -----
// Sieve of Eratosthenes prime counter: one transaction carries an upper limit L (saturated to
// MAX_LIMIT) and returns the number of primes in 2..L. The block holds a single-port bit store
// of MAX_LIMIT+1 entries that allows one access per cycle, and a sequencer whose pointer, base
// and square updates share one adder. A transaction first marks entries 0..L, then for each
// base up to sqrt(L) reads its entry and, if it is still marked, clears its multiples from
// twice the base up to L; last it counts the marked entries in 2..L. The store
// needs no clearing pass: every transaction rewrites entries 0..L first. req_stall stays high
// while a transaction is at work. A finished count waits in the output register, and a new
// transaction may already start.
// Depends on psc_pkg.
module prime_sieve_counter #(
   parameter int MAX_LIMIT = psc_pkg::MAX_LIMIT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [psc_pkg::LIMIT_W-1:0]  req_upper_limit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [psc_pkg::COUNT_W-1:0]  rsp_prime_count
);
   import psc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LIMIT + 1);
   localparam int W      = ADDR_W + 1;
   localparam logic [31:0] MaxLim32 = 32'(MAX_LIMIT);
   localparam logic [W-1:0] MaxLimW = W'(MAX_LIMIT);

   typedef enum logic [2:0] {
      S_IDLE, S_FILL, S_BASE_CHK, S_BASE_WAIT, S_CLEAR, S_ADV_SQ, S_ADV_BASE, S_CNT
   } state_type;

   state_type state_ff, state_in;
   logic [W-1:0] lim_ff, lim_in;
   logic [W-1:0] ptr_ff, ptr_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic pend_ff, pend_in;
   logic done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // shared adder
   logic [W-1:0] alu_a, alu_b, alu_sum;
   logic         alu_cin;

   // bit store
   logic              mem [0:MAX_LIMIT];
   logic              mem_we, mem_wd, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic              rd_data_ff;

   logic req_acc, slot_free;

   assign req_stall       = (state_ff != S_IDLE) || done_ff;
   assign req_acc         = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign slot_free       = !rsp_valid_ff || !rsp_stall;
   assign alu_sum         = alu_a + alu_b + W'(alu_cin);

   always_comb begin
      state_in     = state_ff;
      lim_in       = lim_ff;
      ptr_in       = ptr_ff;
      base_in      = base_ff;
      sq_in        = sq_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      alu_a        = ptr_ff;
      alu_b        = '0;
      alu_cin      = 1'b1;
      mem_we       = 1'b0;
      mem_wd       = 1'b0;
      mem_wa       = ptr_ff[ADDR_W-1:0];
      mem_re       = 1'b0;
      mem_ra       = ptr_ff[ADDR_W-1:0];

      // hand a finished count to the output register once it is free
      if (done_ff && slot_free) begin
         done_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if ({16'd0, req_upper_limit} > MaxLim32) begin
                  lim_in = MaxLimW;
               end else begin
                  lim_in = W'(req_upper_limit);
               end
               ptr_in   = '0;
               count_in = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            mem_wd = 1'b1;
            ptr_in = alu_sum;
            if (ptr_ff == lim_ff) begin
               base_in  = W'(2);
               sq_in    = W'(4);
               state_in = S_BASE_CHK;
            end
         end
         S_BASE_CHK: begin
            if (sq_ff > lim_ff) begin
               ptr_in   = W'(2);
               state_in = S_CNT;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = base_ff[ADDR_W-1:0];
               state_in = S_BASE_WAIT;
            end
         end
         S_BASE_WAIT: begin
            if (rd_data_ff) begin
               ptr_in   = base_ff << 1;
               state_in = S_CLEAR;
            end else begin
               state_in = S_ADV_SQ;
            end
         end
         S_CLEAR: begin
            alu_b   = base_ff;
            alu_cin = 1'b0;
            if (ptr_ff > lim_ff) begin
               state_in = S_ADV_SQ;
            end else begin
               mem_we = 1'b1;
               mem_wd = 1'b0;
               ptr_in = alu_sum;
            end
         end
         S_ADV_SQ: begin
            // (i+1)^2 = i^2 + 2i + 1
            alu_a    = sq_ff;
            alu_b    = base_ff << 1;
            sq_in    = alu_sum;
            state_in = S_ADV_BASE;
         end
         S_ADV_BASE: begin
            alu_a    = base_ff;
            base_in  = alu_sum;
            state_in = S_BASE_CHK;
         end
         S_CNT: begin
            // read data is registered and arrives in the cycle after its address
            if (pend_ff) begin
               count_in = count_ff + COUNT_W'(rd_data_ff);
            end
            if (ptr_ff > lim_ff) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               ptr_in  = alu_sum;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff       <= lim_in;
      ptr_ff       <= ptr_in;
      base_ff      <= base_in;
      sq_ff        <= sq_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

`ifndef SYNTHESIS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (ptr_ff <= lim_ff))
      else $error("bit store write beyond limit");

   a_square_tracks_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BASE_CHK) |->
         ({W'(0), sq_ff} == ({W'(0), base_ff} * {W'(0), base_ff})))
      else $error("square register out of step with base");

   a_accept_starts_fill: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_FILL) && (ptr_ff == '0))
      else $error("accepted transaction did not start the fill");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CNT) |-> ({{W{1'b0}}, count_ff} <= {{COUNT_W{1'b0}}, ptr_ff}))
      else $error("count exceeds entries scanned");

   a_done_loads_output: assert property (@(posedge clock) disable iff (reset)
      (done_ff && slot_free) |=> rsp_valid_ff && !done_ff)
      else $error("finished count not moved to output");
`endif

endmodule
